>>> rtl/core/up_down_counter_with_decimal_scan_assert.svh
// assertion macros used by the counter datapath
`ifndef UP_DOWN_COUNTER_WITH_DECIMAL_SCAN_ASSERT_SVH
`define UP_DOWN_COUNTER_WITH_DECIMAL_SCAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UDC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/udc_pkg.sv
// shared types and constants for the up/down counter with decimal scan
package udc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_EDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd3;

    // configuration reset values
    localparam logic [7:0] STEP_RESET = 8'd1;
    localparam logic [7:0] SCAN_RESET = 8'd5;

    // millisecond counter saturation
    localparam logic [7:0] MS_MAX = 8'd255;

    // quadrature codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // divide by ten through reciprocal, exact for every MAG_W-bit magnitude (up to 131071)
    localparam int MAG_W = 17;
    localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
    localparam int DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_EMIT
    } udc_state_t;

    typedef struct packed {
        logic accept;
        logic load_mag;
        logic conv_step;
        logic emit;
    } udc_cmd_t;

    typedef struct packed {
        logic changed;
        logic conv_last;
        logic out_free;
    } udc_stat_t;

endpackage

>>> rtl/core/udc_ctrl.sv
// sequencer for sample intake, digit conversion and result emit
module udc_ctrl
    import udc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  udc_stat_t stat,
    output udc_cmd_t  cmd
);

    udc_state_t state_reg;
    udc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = stat.changed ? ST_CONV : ST_EMIT;
            end
            ST_CONV:
            begin
                if (stat.conv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.load_mag = 1'b1;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/udc_datapath.sv
// count, digit conversion, scan and output register
`include "up_down_counter_with_decimal_scan_assert.svh"
module udc_datapath
    import udc_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [23:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  udc_cmd_t              cmd,
    output udc_stat_t             stat
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    // configuration
    logic       count_mode_reg;
    logic       active_edge_reg;
    logic [7:0] step_size_reg;
    logic [7:0] scan_period_reg;

    // counter state
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        up_armed_reg;
    logic        down_armed_reg;
    logic [1:0]  last_quad_reg;
    logic        tick_reg;
    logic        changed_reg;

    // conversion
    logic [MAG_W-1:0] mag_reg;
    logic [POS_W-1:0] conv_idx_reg;
    logic [3:0]       digit_reg [DIGIT_COUNT];
    logic [MAG_W+15:0] prod;
    logic [MAG_W-1:0] quot;
    logic [MAG_W-1:0] quot_x10;
    logic [MAG_W-1:0] rem_full;

    // scan
    logic [POS_W-1:0] scan_pos_reg;
    logic [7:0]       ms_elapsed_reg;
    logic [7:0]       ms_sum;
    logic             fire;

    // output word
    logic        m_tvalid_reg;
    logic [15:0] out_count_reg;
    logic [3:0]  out_digit_reg;
    logic [1:0]  out_pos_reg;
    logic        out_write_reg;

    // input fields
    logic       up_pin;
    logic       down_pin;
    logic [1:0] quad_code;
    logic       ms_tick;
    logic       up_act;
    logic       dn_act;
    logic       up_hit;
    logic       dn_hit;
    logic       quad_inc;
    logic       quad_dec;

    assign up_pin    = s_tdata[0];
    assign down_pin  = s_tdata[1];
    assign quad_code = s_tdata[3:2];
    assign ms_tick   = s_tdata[4];

    assign up_act = active_edge_reg ? up_pin : !up_pin;
    assign dn_act = active_edge_reg ? down_pin : !down_pin;
    assign up_hit = up_act && !up_armed_reg;
    assign dn_hit = dn_act && !down_armed_reg;

    assign quad_inc = (last_quad_reg == QUAD_3 && quad_code == QUAD_1) ||
                      (last_quad_reg == QUAD_0 && quad_code == QUAD_2);
    assign quad_dec = (last_quad_reg == QUAD_2 && quad_code == QUAD_0) ||
                      (last_quad_reg == QUAD_1 && quad_code == QUAD_3);

    always_comb
    begin
        count_next = count_reg;
        if (count_mode_reg)
        begin
            if (quad_inc)
            begin
                count_next = count_reg + 16'd1;
            end
            else if (quad_dec)
            begin
                count_next = count_reg - 16'd1;
            end
        end
        else
        begin
            case ({up_hit, dn_hit})
                2'b10:   count_next = count_reg + {8'd0, step_size_reg};
                2'b01:   count_next = count_reg - {8'd0, step_size_reg};
                default: count_next = count_reg;
            endcase
        end
    end

    // one decimal digit per step: quotient by reciprocal, remainder by subtract
    assign prod     = (MAG_W+16)'(mag_reg) * (MAG_W+16)'(DIV10_RECIP);
    assign quot     = MAG_W'(prod >> DIV10_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = mag_reg - quot_x10;

    assign ms_sum = (tick_reg && ms_elapsed_reg != MS_MAX) ? ms_elapsed_reg + 8'd1
                                                            : ms_elapsed_reg;
    assign fire   = ms_sum >= scan_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg  <= 1'b0;
            active_edge_reg <= 1'b0;
            step_size_reg   <= STEP_RESET;
            scan_period_reg <= SCAN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COUNT_MODE:  count_mode_reg  <= cfg_data[0];
                CFG_ACTIVE_EDGE: active_edge_reg <= cfg_data[0];
                CFG_STEP_SIZE:   step_size_reg   <= cfg_data;
                CFG_SCAN_PERIOD: scan_period_reg <= cfg_data;
                default:         step_size_reg   <= step_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            up_armed_reg   <= 1'b0;
            down_armed_reg <= 1'b0;
            last_quad_reg  <= '0;
            tick_reg       <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else if (cmd.accept)
        begin
            count_reg   <= count_next;
            tick_reg    <= ms_tick;
            changed_reg <= count_next != count_reg;
            if (count_mode_reg)
            begin
                last_quad_reg <= quad_code;
            end
            else
            begin
                up_armed_reg   <= up_act;
                down_armed_reg <= dn_act;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_mag)
        begin
            mag_reg <= count_reg[15] ? (MAG_W'(17'h10000) - {1'b0, count_reg})
                                     : {1'b0, count_reg};
        end
        else if (cmd.conv_step)
        begin
            mag_reg <= quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_idx_reg <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else if (cmd.load_mag)
        begin
            conv_idx_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            digit_reg[conv_idx_reg] <= rem_full[3:0];
            conv_idx_reg            <= conv_idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg   <= '0;
            ms_elapsed_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (fire)
            begin
                scan_pos_reg   <= (scan_pos_reg == POS_LAST) ? '0
                                                              : scan_pos_reg + POS_W'(1);
                ms_elapsed_reg <= '0;
            end
            else
            begin
                ms_elapsed_reg <= ms_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_count_reg <= count_reg;
            out_write_reg <= fire;
            out_digit_reg <= fire ? digit_reg[scan_pos_reg] : 4'd0;
            out_pos_reg   <= fire ? 2'(scan_pos_reg) : 2'd0;
        end
    end

    assign stat.changed   = changed_reg;
    assign stat.conv_last = conv_idx_reg == POS_LAST;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_digit_reg, out_count_reg};
    assign m_tuser  = out_write_reg;

    `UDC_ASSERT_NEXT(a_emit_loads, clk, rst_n, cmd.emit, m_tvalid_reg,
        "emit did not load the output word")
    `UDC_ASSERT_SAME(a_digit_range, clk, rst_n, m_tvalid_reg && out_write_reg,
        out_digit_reg <= 4'd9, "digit out of decimal range")
    `UDC_ASSERT_SAME(a_blank_digit, clk, rst_n, m_tvalid_reg && !out_write_reg,
        out_digit_reg == 4'd0 && out_pos_reg == 2'd0, "digit fields not blank")
    `UDC_ASSERT_SAME(a_scan_range, clk, rst_n, 1'b1, scan_pos_reg <= POS_LAST,
        "scan position past last digit")

endmodule

>>> rtl/core/up_down_counter_with_decimal_scan.sv
// each accepted word passes load, the divide-by-ten digit loop (only when the count changed) and emit
// a new word is taken only once the previous one is emitted; emit waits until the output register is free
// the next word is accepted while the previous result waits in the output register
// reset: asynchronous active-low rst_n clears count, arming, scan and digits
// reset config: pin mode, falling edge, step 1, scan period 5 ms
module up_down_counter_with_decimal_scan
    import udc_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input word
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // up_pin, down_pin, quad_code[1:0], ms_tick, pad
    // result word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // count_value[15:0], digit_value[3:0],
                                             // digit_position[1:0], pad
    output logic                  m_tuser,   // digit_write
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    udc_cmd_t  cmd;
    udc_stat_t stat;

    // config writes land at once, the block is idle by contract
    assign cfg_ready = 1'b1;

    // sequencer: idle -> load magnitude -> convert digits (only on change) -> emit
    udc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // counter, digit store, scan timer and output register
    udc_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> bench/udc_scan_checker.sv
// scoreboard for the up/down counter: predicts each result word and checks the output stream
`timescale 1ns / 1ps

module udc_scan_checker
    import udc_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [15:0] count;
        logic [3:0]  digit;
        logic [1:0]  pos;
        logic        write;
    } display_word_t;

    display_word_t display_queue[$];

    // register copies
    logic       mode_q;
    logic       edge_q;
    logic [7:0] step_q;
    logic [7:0] scan_q;

    // counter and display state
    logic [15:0] count_q;
    logic        up_armed_q;
    logic        dn_armed_q;
    logic [1:0]  last_quad_q;
    logic [15:0] converted_q;
    logic [3:0]  digits_q[DIGITS];
    int          scan_pos_q;
    logic [7:0]  ms_q;

    int mismatches = 0;
    int results_seen = 0;

    assign errors = mismatches;

    task automatic flag_error(input string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic predict_display(input logic [7:0] w);
        logic        up_lvl;
        logic        dn_lvl;
        logic        tick;
        logic        up_act;
        logic        dn_act;
        logic [1:0]  code;
        logic [16:0] mag;
        int          p;
        int          k;
        display_word_t exp_w;
        up_lvl = w[0];
        dn_lvl = w[1];
        code   = w[3:2];
        tick   = w[4];
        exp_w  = '0;
        if (mode_q) begin
            if (code != last_quad_q) begin
                if ((last_quad_q == QUAD_3 && code == QUAD_1) ||
                    (last_quad_q == QUAD_0 && code == QUAD_2))
                    count_q = count_q + 16'd1;
                else if ((last_quad_q == QUAD_2 && code == QUAD_0) ||
                         (last_quad_q == QUAD_1 && code == QUAD_3))
                    count_q = count_q - 16'd1;
                last_quad_q = code;
            end
        end
        else begin
            up_act = edge_q ? up_lvl : !up_lvl;
            dn_act = edge_q ? dn_lvl : !dn_lvl;
            if (up_act && !up_armed_q) begin
                count_q = count_q + {8'd0, step_q};
                up_armed_q = 1'b1;
            end
            else if (!up_act && up_armed_q)
                up_armed_q = 1'b0;
            if (dn_act && !dn_armed_q) begin
                count_q = count_q - {8'd0, step_q};
                dn_armed_q = 1'b1;
            end
            else if (!dn_act && dn_armed_q)
                dn_armed_q = 1'b0;
        end
        // digits follow the magnitude, the sign is dropped
        if (count_q != converted_q) begin
            mag = count_q[15] ? (17'h10000 - {1'b0, count_q}) : {1'b0, count_q};
            for (k = 0; k < DIGITS; k++) begin
                digits_q[k] = 4'(mag % 17'd10);
                mag = mag / 17'd10;
            end
            converted_q = count_q;
        end
        if (tick && ms_q < MS_MAX)
            ms_q = ms_q + 8'd1;
        if (ms_q >= scan_q) begin
            p = (scan_pos_q < DIGITS) ? scan_pos_q : 0;
            exp_w.write = 1'b1;
            exp_w.digit = digits_q[p];
            exp_w.pos   = p[1:0];
            p++;
            if (p >= DIGITS)
                p = 0;
            scan_pos_q = p;
            ms_q = 8'd0;
        end
        exp_w.count = count_q;
        display_queue.push_back(exp_w);
    endtask

    task automatic check_display();
        display_word_t want;
        if (display_queue.size() == 0)
            flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
        else begin
            want = display_queue.pop_front();
            if (m_tdata[15:0] !== want.count)
                flag_error($sformatf("result %0d count_value got %0d want %0d", results_seen,
                                     $signed(m_tdata[15:0]), $signed(want.count)));
            if (m_tdata[19:16] !== want.digit)
                flag_error($sformatf("result %0d digit_value got %0d want %0d", results_seen,
                                     m_tdata[19:16], want.digit));
            if (m_tdata[21:20] !== want.pos)
                flag_error($sformatf("result %0d digit_position got %0d want %0d",
                                     results_seen, m_tdata[21:20], want.pos));
            if (m_tuser !== want.write)
                flag_error($sformatf("result %0d digit_write got %0b want %0b", results_seen,
                                     m_tuser, want.write));
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_q      = 1'b0;
            edge_q      = 1'b0;
            step_q      = STEP_RESET;
            scan_q      = SCAN_RESET;
            count_q     = '0;
            up_armed_q  = 1'b0;
            dn_armed_q  = 1'b0;
            last_quad_q = QUAD_0;
            converted_q = '0;
            for (int i = 0; i < DIGITS; i++)
                digits_q[i] = '0;
            scan_pos_q  = 0;
            ms_q        = '0;
            display_queue.delete();
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COUNT_MODE:  mode_q = cfg_data[0];
                    CFG_ACTIVE_EDGE: edge_q = cfg_data[0];
                    CFG_STEP_SIZE:   step_q = cfg_data;
                    CFG_SCAN_PERIOD: scan_q = cfg_data;
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier word, so check before predicting
            if (m_tvalid && m_tready)
                check_display();
            if (s_tvalid && s_tready)
                predict_display(s_tdata);
            pending <= display_queue.size();
        end
    end

endmodule

>>> bench/tb_up_down_counter_with_decimal_scan.sv
// testbench top: drives pin samples and register writes, and gives the verdict
`timescale 1ns / 1ps

module tb_up_down_counter_with_decimal_scan;
    import udc_pkg::*;

    localparam int DIGIT_COUNT = 4;
    localparam int TARGET_WORDS = 1250;

    // register values
    localparam logic MODE_PINS = 1'b0;
    localparam logic MODE_QUAD = 1'b1;
    localparam logic EDGE_FALL = 1'b0;
    localparam logic EDGE_RISE = 1'b1;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors;
    int pending;

    // sender bookkeeping
    int   words_sent = 0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;
    logic hold_request = 1'b0;

    // levels last driven on the pins and the encoder
    logic       pin_up = 1'b0;
    logic       pin_dn = 1'b0;
    logic [1:0] quad_now = QUAD_0;

    up_down_counter_with_decimal_scan #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    udc_scan_checker #(
        .DIGITS(DIGIT_COUNT)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: switches between stall styles, with one long hold-off on request
    initial
    begin
        int        hold_cycles;
        int        style_left;
        rx_style_t style;
        hold_cycles = 0;
        style_left  = 0;
        style       = RX_FREE;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                hold_cycles = 300;
            end
            if (hold_cycles > 0) begin
                // long stall so the output register and the input side back up
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else begin
                if (style_left == 0) begin
                    style = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 128);
                end
                style_left--;
                case (style)
                    RX_FREE:     m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= (style_left % 3 == 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // tdata: up_pin, down_pin, quad_code[1:0], ms_tick, pad
    function automatic logic [7:0] pack_sample(input logic up, input logic dn,
                                               input logic [1:0] code, input logic tick);
        return {3'b000, tick, code, dn, up};
    endfunction

    // one register write, valid dropped afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the digit loop settle before touching the registers
        repeat (DIGIT_COUNT + 6) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_regs(input logic mode, input logic edge_sel, input logic [7:0] step,
                            input logic [7:0] scan);
        write_reg(CFG_COUNT_MODE, {7'd0, mode});
        write_reg(CFG_ACTIVE_EDGE, {7'd0, edge_sel});
        write_reg(CFG_STEP_SIZE, step);
        write_reg(CFG_SCAN_PERIOD, scan);
    endtask

    // offer one word; bursts of random length separated by random gaps
    task automatic send_sample(input logic [7:0] w);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pin_up   = w[0];
        pin_dn   = w[1];
        quad_now = w[3:2];
        words_sent++;
    endtask

    // random sample shaped for the mode: pins toggle, encoder mostly steps one code
    function automatic logic [7:0] random_sample(input logic mode, input int tick_pct,
                                                 input int toggle_pct);
        logic       up;
        logic       dn;
        logic [1:0] code;
        int         roll;
        up   = ($urandom_range(0, 99) < toggle_pct) ? ~pin_up : pin_up;
        dn   = ($urandom_range(0, 99) < toggle_pct) ? ~pin_dn : pin_dn;
        code = quad_now;
        if (mode == MODE_QUAD) begin
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                // gray order 0 1 3 2
                case (quad_now)
                    QUAD_0:  code = QUAD_1;
                    QUAD_1:  code = QUAD_3;
                    QUAD_3:  code = QUAD_2;
                    default: code = QUAD_0;
                endcase
            end
            else if (roll < 8) begin
                case (quad_now)
                    QUAD_0:  code = QUAD_2;
                    QUAD_2:  code = QUAD_3;
                    QUAD_3:  code = QUAD_1;
                    default: code = QUAD_0;
                endcase
            end
            else if (roll == 9)
                code = 2'($urandom_range(0, 3));
        end
        else
            code = 2'($urandom_range(0, 3));
        return pack_sample(up, dn, code, ($urandom_range(0, 99) < tick_pct));
    endfunction

    task automatic run_phase(input logic mode, input logic edge_sel, input logic [7:0] step,
                             input logic [7:0] scan, input int n, input int tick_pct,
                             input int toggle_pct);
        wait_for_drain();
        set_regs(mode, edge_sel, step, scan);
        repeat (n) send_sample(random_sample(mode, tick_pct, toggle_pct));
    endtask

    function automatic logic [7:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_scan();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(2, 8));
        endcase
    endfunction

    initial
    begin
        logic [1:0] quad_walk[12];
        quad_walk = '{QUAD_2, QUAD_3, QUAD_1, QUAD_0, QUAD_1, QUAD_3,
                      QUAD_2, QUAD_0, QUAD_3, QUAD_1, QUAD_2, QUAD_0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ramp from zero down to the most negative count and wrap past it:
        // falling edges of 255, then edges of 128
        set_regs(MODE_PINS, EDGE_FALL, 8'd255, 8'd1);
        repeat (128)
        begin
            send_sample(pack_sample(1'b1, 1'b0, 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1))));
            send_sample(pack_sample(1'b1, 1'b1, 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1))));
        end
        wait_for_drain();
        write_reg(CFG_STEP_SIZE, 8'd128);
        repeat (2)
        begin
            send_sample(pack_sample(1'b1, 1'b0, QUAD_0, 1'b1));
            send_sample(pack_sample(1'b1, 1'b1, QUAD_3, 1'b1));
        end

        // directed: rising edges, digit on every sample, both pins at once
        wait_for_drain();
        set_regs(MODE_PINS, EDGE_RISE, 8'd1, 8'd0);
        send_sample(pack_sample(1'b0, 1'b0, QUAD_0, 1'b0));
        send_sample(pack_sample(1'b1, 1'b1, QUAD_3, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, QUAD_3, 1'b1));
        send_sample(pack_sample(1'b0, 1'b1, QUAD_1, 1'b0));
        send_sample(pack_sample(1'b1, 1'b0, QUAD_2, 1'b1));
        send_sample(pack_sample(1'b0, 1'b0, QUAD_0, 1'b1));
        send_sample(pack_sample(1'b1, 1'b0, QUAD_3, 1'b0));
        // zero step, with both pins rising at once, so the edges cancel and the count holds
        wait_for_drain();
        write_reg(CFG_STEP_SIZE, 8'd0);
        send_sample(pack_sample(1'b0, 1'b0, QUAD_1, 1'b1));
        send_sample(pack_sample(1'b1, 1'b1, QUAD_2, 1'b1));
        // encoder walk over all four counting code changes and several others, pins ignored
        wait_for_drain();
        set_regs(MODE_QUAD, EDGE_FALL, 8'd1, 8'd1);
        foreach (quad_walk[i])
            send_sample(pack_sample(1'(i), 1'(i >> 1), quad_walk[i], 1'(i)));

        // receiver holds off while the sender keeps offering back to back
        wait_for_drain();
        set_regs(MODE_PINS, EDGE_FALL, 8'd7, 8'd0);
        gaps_on = 1'b0;
        hold_request <= 1'b1;
        repeat (60) send_sample(random_sample(MODE_PINS, 50, 50));
        gaps_on = 1'b1;

        // longest scan period with a tick on every sample
        run_phase(MODE_QUAD, EDGE_RISE, 8'd3, 8'd255, 270, 100, 40);

        // random settings until the word budget is spent
        while (words_sent < TARGET_WORDS)
            run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_step(),
                      pick_scan(), $urandom_range(40, 120), $urandom_range(20, 100),
                      $urandom_range(20, 80));

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
